// ----- rtl/stk_srt_pkg.sv -----
// Shared types and constants for the stack_with_sort block.
// Holds operation and status codes, sequencer states and the default depth.
// No dependencies.
`timescale 1ns / 1ps

package stk_srt_pkg;

	// Default number of entries the stack holds.
	localparam int DEFAULT_DEPTH = 16;

	// Value returned by pop, peek or sort on an empty stack.
	localparam logic [31:0] EMPTY_VALUE = 32'hFFFF_FFFF;

	// Operation codes carried by an input transaction.
	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_PEEK = 2'd2,
		OP_SORT = 2'd3
	} op_t;

	// Status codes carried by a result transaction.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Sequencer states, one-hot.
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_PRD  = 6'b000010,
		S_SRD  = 6'b000100,
		S_SCMP = 6'b001000,
		S_SWB  = 6'b010000,
		S_RESP = 6'b100000
	} state_t;

endpackage

// ----- rtl/stack_with_sort.sv -----
// stack_with_sort: bounded LIFO of signed 32-bit values with in-place sort.
// Push and any operation on an empty stack answer in the cycle after acceptance, so they
// run one per cycle while the output is not stalled; pop and peek answer through a
// registered memory read and a held result value, taking no new operation meanwhile. Sort
// runs bubble passes of one shared compare unit and is likewise busy until it answers.
// Reset (arst_n low, asynchronous) empties the stack; the storage itself is not cleared.
`timescale 1ns / 1ps

module stack_with_sort #(
	parameter int DEPTH = stk_srt_pkg::DEFAULT_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic signed [31:0] push_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] read_value,
	output logic [1:0]         status
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	stk_srt_pkg::state_t state_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       cnt_m1;
	logic [IW-1:0]       top_idx;
	logic [IW-1:0]       idx_q;
	logic [IW-1:0]       last_q;
	logic signed [31:0]  carry_q;
	logic signed [31:0]  rdata_q;
	logic signed [31:0]  res_val_q;
	logic                out_valid_q;
	logic signed [31:0]  read_value_q;
	logic [1:0]          status_q;
	logic [31:0]         mem [DEPTH];

	logic                in_acc;
	logic                out_free;
	logic                full;
	logic                empty;
	stk_srt_pkg::op_t    op;
	logic [IW-1:0]       rd_addr;
	logic                wr_en;
	logic [IW-1:0]       wr_addr;
	logic signed [31:0]  wr_data;
	logic                gt;
	logic signed [31:0]  cmp_max;
	logic signed [31:0]  cmp_min;
	logic                ld_out;
	logic signed [31:0]  ld_val;
	stk_srt_pkg::status_t ld_st;

	// Handshake and stack occupancy.
	assign op        = stk_srt_pkg::op_t'(operation);
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != stk_srt_pkg::S_IDLE) || !out_free;
	assign in_acc    = in_valid && !in_stall;
	assign full      = (cnt_q == CW'(DEPTH));
	assign empty     = (cnt_q == '0);
	assign cnt_m1    = cnt_q - CW'(1);
	assign top_idx   = cnt_m1[IW-1:0];
	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;

	// Shared compare unit: the larger value sinks, the smaller rides upward.
	assign gt      = rdata_q > carry_q;
	assign cmp_max = gt ? rdata_q : carry_q;
	assign cmp_min = gt ? carry_q : rdata_q;

	// Read address: the top of stack while idle, the sweep index while sorting.
	assign rd_addr = (state_q == stk_srt_pkg::S_IDLE) ? top_idx : idx_q;

	// Single write port of the storage.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q[IW-1:0];
		wr_data = push_value;
		if (in_acc && op == stk_srt_pkg::OP_PUSH && !full) begin
			wr_en = 1'b1;
		end else if (state_q == stk_srt_pkg::S_SCMP && idx_q != '0) begin
			wr_en   = 1'b1;
			wr_addr = idx_q - IW'(1);
			wr_data = cmp_max;
		end else if (state_q == stk_srt_pkg::S_SWB) begin
			wr_en   = 1'b1;
			wr_addr = last_q;
			wr_data = carry_q;
		end
	end

	// Storage with registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	// Result loading into the output register.
	always_comb begin
		ld_out = 1'b0;
		ld_val = '0;
		ld_st  = stk_srt_pkg::ST_OK;
		if (in_acc) begin
			if (op == stk_srt_pkg::OP_PUSH) begin
				ld_out = 1'b1;
				ld_st  = full ? stk_srt_pkg::ST_FULL : stk_srt_pkg::ST_OK;
			end else if (empty) begin
				ld_out = 1'b1;
				ld_val = stk_srt_pkg::EMPTY_VALUE;
				ld_st  = stk_srt_pkg::ST_EMPTY;
			end
		end else if (state_q == stk_srt_pkg::S_RESP && out_free) begin
			ld_out = 1'b1;
			ld_val = res_val_q;
		end
	end

	// Sequencer and stack count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= stk_srt_pkg::S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				stk_srt_pkg::S_IDLE: begin
					if (in_acc && (!empty || op == stk_srt_pkg::OP_PUSH)) begin
						unique case (op)
							stk_srt_pkg::OP_PUSH: begin
								if (!full) begin
									cnt_q <= cnt_q + CW'(1);
								end
							end
							stk_srt_pkg::OP_POP: begin
								cnt_q   <= cnt_m1;
								state_q <= stk_srt_pkg::S_PRD;
							end
							stk_srt_pkg::OP_PEEK: begin
								state_q <= stk_srt_pkg::S_PRD;
							end
							stk_srt_pkg::OP_SORT: begin
								state_q <= stk_srt_pkg::S_SRD;
							end
							default: begin
								state_q <= stk_srt_pkg::S_IDLE;
							end
						endcase
					end
				end
				stk_srt_pkg::S_PRD: begin
					state_q <= stk_srt_pkg::S_RESP;
				end
				stk_srt_pkg::S_SRD: begin
					state_q <= stk_srt_pkg::S_SCMP;
				end
				stk_srt_pkg::S_SCMP: begin
					state_q <= (idx_q == last_q) ? stk_srt_pkg::S_SWB : stk_srt_pkg::S_SRD;
				end
				stk_srt_pkg::S_SWB: begin
					state_q <= (last_q <= IW'(1)) ? stk_srt_pkg::S_RESP : stk_srt_pkg::S_SRD;
				end
				stk_srt_pkg::S_RESP: begin
					if (out_free) begin
						state_q <= stk_srt_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= stk_srt_pkg::S_IDLE;
				end
			endcase
		end
	end

	// Sort sweep registers and held result value.
	always_ff @(posedge clk) begin
		unique case (state_q)
			stk_srt_pkg::S_IDLE: begin
				idx_q  <= '0;
				last_q <= top_idx;
			end
			stk_srt_pkg::S_PRD: begin
				res_val_q <= rdata_q;
			end
			stk_srt_pkg::S_SCMP: begin
				carry_q <= (idx_q == '0) ? rdata_q : cmp_min;
				if (idx_q != last_q) begin
					idx_q <= idx_q + IW'(1);
				end
			end
			stk_srt_pkg::S_SWB: begin
				// The first pass leaves the overall minimum on top.
				if (last_q == top_idx) begin
					res_val_q <= carry_q;
				end
				idx_q  <= '0;
				last_q <= last_q - IW'(1);
			end
			default: begin
			end
		endcase
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (ld_out) begin
			read_value_q <= ld_val;
			status_q     <= ld_st;
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("stack count exceeds depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && op == stk_srt_pkg::OP_PUSH && !full) |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("accepted push did not grow the stack");

	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != stk_srt_pkg::S_IDLE) |=> $stable(cnt_q))
		else $error("stack count changed during a multi-cycle operation");

	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == stk_srt_pkg::S_SCMP) |-> (idx_q <= last_q && {1'b0, last_q} < cnt_q))
		else $error("sort sweep index outside the stack");

	a_empty_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == stk_srt_pkg::ST_EMPTY) |->
		read_value_q == stk_srt_pkg::EMPTY_VALUE)
		else $error("empty status without the empty value");
`endif

endmodule
